### sv/swm_pkg.sv
package swm_pkg;

   localparam int WINDOW_MAX   = 64;
   localparam int SAMPLE_WIDTH = 32;
   localparam int SIZE_WIDTH   = 7;
   localparam int SEEN_WIDTH   = $clog2(WINDOW_MAX + 1);
   // Cell k holds the maximum of the newest k+1 samples; the newest sample
   // itself closes the chain in the top level, so one cell fewer is needed.
   localparam int CHAIN_LEN    = WINDOW_MAX - 1;
   localparam int INDEX_WIDTH  = (CHAIN_LEN > 1) ? $clog2(CHAIN_LEN) : 1;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [SIZE_WIDTH-1:0]          size_type;
   typedef logic [SEEN_WIDTH-1:0]          seen_type;
   typedef logic [INDEX_WIDTH-1:0]         index_type;

   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   function automatic sample_type sample_max(input sample_type a, input sample_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

### sv/swm_cell.sv
module swm_cell (
   input  logic                clock,
   input  logic                shift,
   input  swm_pkg::sample_type sample,
   input  swm_pkg::sample_type prev_max,
   output swm_pkg::sample_type run_max
);

   swm_pkg::sample_type max_ff;
   swm_pkg::sample_type max_in;

   // The new sample widens the window of the neighbour by one place.
   assign max_in  = swm_pkg::sample_max(sample, prev_max);
   assign run_max = max_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         max_ff <= max_in;
      end
   end

endmodule

### sv/sliding_window_maximum_filter_top.sv
// The result of a request is registered and shows on rsp_ after the edge that accepts it.
// Throughput: one request per cycle, set by the row of maximum cells that all update together,
// if no held result stalls. Requests that yield no result are still taken at one per cycle.
// Reset clears the sample count, the output valid flag and sets the window size to 1;
// the cells are not reset, as no result reads a cell written before the current sequence.
module sliding_window_maximum_filter_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [swm_pkg::SAMPLE_WIDTH-1:0]      req_tdata,  // [31:0] sample
   input  logic                                  req_tuser,  // [0] first
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [swm_pkg::SAMPLE_WIDTH-1:0]      rsp_tdata,  // [31:0] window_max
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [swm_pkg::SIZE_WIDTH-1:0]        csr_data
);

   swm_pkg::size_type   win_size_ff;
   swm_pkg::seen_type   seen_ff;
   swm_pkg::seen_type   seen_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   swm_pkg::sample_type rsp_data_ff;
   swm_pkg::sample_type rsp_data_in;

   swm_pkg::sample_type cell_max [swm_pkg::CHAIN_LEN];
   swm_pkg::sample_type sample;
   swm_pkg::size_type   win_eff;
   swm_pkg::size_type   win_less2;
   swm_pkg::index_type  sel;
   logic                accept;
   logic                emit;

   assign sample     = swm_pkg::sample_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   genvar g;
   generate
      for (g = 0; g < swm_pkg::CHAIN_LEN; g++) begin : g_cell
         if (g == 0) begin : g_head
            swm_cell u_cell (
               .clock    (clock),
               .shift    (accept),
               .sample   (sample),
               .prev_max (swm_pkg::SAMPLE_MIN),
               .run_max  (cell_max[g])
            );
         end else begin : g_body
            swm_cell u_cell (
               .clock    (clock),
               .shift    (accept),
               .sample   (sample),
               .prev_max (cell_max[g-1]),
               .run_max  (cell_max[g])
            );
         end
      end
   endgenerate

   // A window size of zero behaves as a window of one.
   assign win_eff   = (win_size_ff == '0) ? swm_pkg::size_type'(1) : win_size_ff;
   assign win_less2 = win_eff - swm_pkg::size_type'(2);
   assign sel       = win_less2[swm_pkg::INDEX_WIDTH-1:0];

   always_comb begin
      if (req_tuser) begin
         seen_in = swm_pkg::seen_type'(1);
      end else if (seen_ff < swm_pkg::seen_type'(swm_pkg::WINDOW_MAX)) begin
         seen_in = seen_ff + swm_pkg::seen_type'(1);
      end else begin
         seen_in = seen_ff;
      end
   end

   assign emit = (win_eff <= swm_pkg::size_type'(swm_pkg::WINDOW_MAX)) &&
                 (swm_pkg::size_type'(seen_in) >= win_eff);

   // Above a window of one, the result is the new sample against the cell that covers the older
   // window_size - 1 samples, taken before the row shifts; a window of one passes the sample alone.
   always_comb begin
      if (win_eff == swm_pkg::size_type'(1)) begin
         rsp_data_in = sample;
      end else begin
         rsp_data_in = swm_pkg::sample_max(sample, cell_max[sel]);
      end
   end

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff  <= swm_pkg::size_type'(1);
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            win_size_ff <= csr_data;
         end
         if (accept) begin
            seen_ff <= seen_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_seen_bounded : assert property (@(posedge clock) disable iff (reset)
      seen_ff <= swm_pkg::seen_type'(swm_pkg::WINDOW_MAX))
      else $error("sample count beyond the window limit");

   a_unit_window_passes : assert property (@(posedge clock) disable iff (reset)
      (accept && win_eff == swm_pkg::size_type'(1))
      |=> (rsp_tvalid && rsp_tdata == $past(req_tdata)))
      else $error("unit window did not pass the sample through");

   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while a result is held");

   a_new_sequence_short : assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser && win_eff > swm_pkg::size_type'(1)) |=> !rsp_tvalid)
      else $error("result given for a sequence shorter than the window");

endmodule
